### hdl/tra_pkg.sv
// Package for traffic_row_advance: shared types, codes and widths.
`default_nettype none

package tra_pkg;

    // Default parameter values
    localparam int MAX_CARS_DEF       = 32;
    localparam int MAX_ROW_LENGTH_DEF = 1024;

    // Field widths
    localparam int ACT_W    = 2;
    localparam int POS_W    = 10;
    localparam int IDX_W    = 5;
    localparam int COUNT_W  = 6;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 11;
    localparam int LIM_W    = 17;   // holds the largest row length limit

    localparam logic [LEN_W-1:0] ROW_LEN_RESET = LEN_W'(256);

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_MOVE   = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    // One stored car
    typedef struct packed {
        logic             color;
        logic [POS_W-1:0] pos;
    } t_car;

endpackage

`default_nettype wire

### hdl/tra_ifs.sv
// Valid/ready channel interfaces for item and result beats.
`default_nettype none

interface tra_in_if;
    import tra_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] car_position;
    logic             car_color;
    logic             move_color;
    logic [IDX_W-1:0] read_index;

    modport source (output valid, action, car_position, car_color, move_color, read_index,
                    input ready);
    modport sink   (input valid, action, car_position, car_color, move_color, read_index,
                    output ready);
endinterface

interface tra_out_if;
    import tra_pkg::*;

    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   entry_position;
    logic               entry_color;
    logic [COUNT_W-1:0] car_count;
    logic               row_empty;
    logic [STAT_W-1:0]  status;

    modport source (output valid, entry_position, entry_color, car_count, row_empty, status,
                    input ready);
    modport sink   (input valid, entry_position, entry_color, car_count, row_empty, status,
                    output ready);
endinterface

`default_nettype wire

### hdl/tra_car_ram.sv
// Car store RAM: one write port, one read port, registered read data.
`default_nettype none

module tra_car_ram #(
    parameter int DEPTH  = tra_pkg::MAX_CARS_DEF,
    parameter int ADDR_W = 5
) (
    input  wire                i_clk,
    input  wire                i_we,
    input  wire [ADDR_W-1:0]   i_waddr,
    input  wire tra_pkg::t_car i_wdata,
    input  wire [ADDR_W-1:0]   i_raddr,
    output tra_pkg::t_car      o_rdata
);
    import tra_pkg::*;

    t_car r_mem [DEPTH];
    t_car r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/traffic_row_advance.sv
// Top level: circular traffic row kept as a ring of cars in a RAM.
// Sequence: append and unused action go straight to the result stage, read waits on the
//   RAM read, move reads each stored car in turn (one RAM read per stored car, then the
//   last-car step); a move on an empty row goes straight to the result stage.
// Throughput: one item at a time; the next beat is taken once the result is in the output
//   register, even while that result still waits to be taken.
// Reset (synchronous, active low): ring empty, head at 0, row length 256, no result
//   pending. Store contents are not cleared; only entries below the count are read.
`default_nettype none

module traffic_row_advance #(
    parameter int MAX_CARS       = tra_pkg::MAX_CARS_DEF,
    parameter int MAX_ROW_LENGTH = tra_pkg::MAX_ROW_LENGTH_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire [tra_pkg::LEN_W-1:0]  i_cfg_wdata,
    tra_in_if.sink                    i_in,
    tra_out_if.source                 o_out
);
    import tra_pkg::*;

    localparam int PTR_W = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CNT_W = $clog2(MAX_CARS + 1);

    // (head + idx) mod MAX_CARS; both operands are below MAX_CARS
    function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] head,
                                                   input logic [CNT_W-1:0] idx);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + (PTR_W+1)'(idx);
        if (sum >= (PTR_W+1)'(MAX_CARS)) begin
            sum = sum - (PTR_W+1)'(MAX_CARS);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] s);
        logic [PTR_W-1:0] r;
        r = (s == PTR_W'(MAX_CARS - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] s);
        logic [PTR_W-1:0] r;
        r = (s == '0) ? PTR_W'(MAX_CARS - 1) : s - 1'b1;
        return r;
    endfunction

    // ---------------- state ----------------
    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_row_len;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_idx, n_idx;           // index of the entry arriving from RAM
    logic [PTR_W-1:0]   r_rd_slot, n_rd_slot;   // its slot
    t_car               r_prev, n_prev;         // entry one behind, waiting on its verdict
    logic [PTR_W-1:0]   r_prev_slot, n_prev_slot;
    logic [POS_W-1:0]   r_first_old, n_first_old;
    logic               r_mcol, n_mcol;

    // staged result
    logic [POS_W-1:0]   r_res_pos, n_res_pos;
    logic               r_res_col, n_res_col;
    t_status            r_res_stat, n_res_stat;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic               r_out_col, n_out_col;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic               r_out_empty, n_out_empty;
    t_status            r_out_stat, n_out_stat;

    // RAM ports
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    t_car               ram_wdata;
    logic [PTR_W-1:0]   ram_raddr;
    t_car               ram_rdata;

    // effective row length, clamped to the configured maximum
    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W+1:0]   first_plus_len;   // first car's old position + row length
    logic [LEN_W-1:0]   last_nv;          // last car's candidate position
    logic               last_step;

    tra_car_ram #(
        .DEPTH  (MAX_CARS),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign len_eff = (LIM_W'(r_row_len) > LIM_W'(MAX_ROW_LENGTH))
                   ? LEN_W'(MAX_ROW_LENGTH) : r_row_len;

    assign first_plus_len = (LEN_W+2)'(r_first_old) + (LEN_W+2)'(len_eff);
    assign last_step = (r_prev.color == r_mcol)
                    && (((LEN_W+2)'(r_prev.pos) + 1'b1) < first_plus_len);
    assign last_nv = LEN_W'(r_prev.pos) + LEN_W'(last_step);

    // ---------------- handshakes ----------------
    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.entry_position = r_out_pos;
    assign o_out.entry_color    = r_out_col;
    assign o_out.car_count      = r_out_count;
    assign o_out.row_empty      = r_out_empty;
    assign o_out.status         = r_out_stat;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_len   <= ROW_LEN_RESET;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_row_len <= i_cfg_wdata;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_rd_slot   <= n_rd_slot;
        r_prev      <= n_prev;
        r_prev_slot <= n_prev_slot;
        r_first_old <= n_first_old;
        r_mcol      <= n_mcol;
        r_res_pos   <= n_res_pos;
        r_res_col   <= n_res_col;
        r_res_stat  <= n_res_stat;
        r_out_pos   <= n_out_pos;
        r_out_col   <= n_out_col;
        r_out_count <= n_out_count;
        r_out_empty <= n_out_empty;
        r_out_stat  <= n_out_stat;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_rd_slot   = r_rd_slot;
        n_prev      = r_prev;
        n_prev_slot = r_prev_slot;
        n_first_old = r_first_old;
        n_mcol      = r_mcol;
        n_res_pos   = r_res_pos;
        n_res_col   = r_res_col;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_pos   = r_out_pos;
        n_out_col   = r_out_col;
        n_out_count = r_out_count;
        n_out_empty = r_out_empty;
        n_out_stat  = r_out_stat;
        ram_we      = 1'b0;
        ram_waddr   = r_prev_slot;
        ram_wdata   = r_prev;
        ram_raddr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (t_action'(i_in.action) == ACT_READ) begin
                    ram_raddr = ring_slot(r_head, CNT_W'(i_in.read_index));
                end
                if (i_in.valid) begin
                    n_mcol     = i_in.move_color;
                    n_res_pos  = '0;
                    n_res_col  = 1'b0;
                    n_res_stat = ST_OK;
                    n_state    = S_DONE;
                    unique case (t_action'(i_in.action))
                        ACT_APPEND: begin
                            if (r_count >= CNT_W'(MAX_CARS)) begin
                                n_res_stat = ST_FULL;
                            end else begin
                                ram_we          = 1'b1;
                                ram_waddr       = ring_slot(r_head, r_count);
                                ram_wdata.pos   = i_in.car_position;
                                ram_wdata.color = i_in.car_color;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        ACT_MOVE: begin
                            // empty row: nothing to do
                            if (r_count != '0) begin
                                n_idx     = '0;
                                n_rd_slot = r_head;
                                n_state   = S_SCAN;
                            end
                        end
                        ACT_READ: begin
                            if (8'(i_in.read_index) >= 8'(r_count)) begin
                                n_res_stat = ST_RANGE;
                            end else begin
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: ;  // unused action code
                    endcase
                end
            end

            S_RD_WAIT: begin
                n_res_pos = ram_rdata.pos;
                n_res_col = ram_rdata.color;
                n_state   = S_DONE;
            end

            S_SCAN: begin
                // ram_rdata is entry r_idx; r_prev is entry r_idx-1 (old values)
                if (r_idx == '0) begin
                    n_first_old = ram_rdata.pos;
                end else if ((r_prev.color == r_mcol)
                          && ((LEN_W'(r_prev.pos) + 1'b1) < LEN_W'(ram_rdata.pos))) begin
                    ram_we        = 1'b1;
                    ram_waddr     = r_prev_slot;
                    ram_wdata.pos = r_prev.pos + 1'b1;
                end
                n_prev      = ram_rdata;
                n_prev_slot = r_rd_slot;
                if (CNT_W'(r_idx + 1'b1) < r_count) begin
                    ram_raddr = slot_inc(r_rd_slot);
                    n_rd_slot = slot_inc(r_rd_slot);
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_state = S_LAST;
                end
            end

            S_LAST: begin
                // last car: checked against first car's old position one lap on
                ram_we = 1'b1;
                if (last_nv >= len_eff) begin
                    // wraps to cell 0 and becomes the first entry
                    n_head          = slot_dec(r_head);
                    ram_waddr       = slot_dec(r_head);
                    ram_wdata.pos   = '0;
                    ram_wdata.color = r_prev.color;
                end else begin
                    ram_waddr     = r_prev_slot;
                    ram_wdata.pos = last_nv[POS_W-1:0];
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_res_pos;
                    n_out_col   = r_res_col;
                    n_out_stat  = r_res_stat;
                    n_out_count = COUNT_W'(r_count);
                    n_out_empty = (r_count == '0);
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CARS))
        else $error("car count above store depth");

    a_count_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_count))
        else $error("car count changed outside an append");

    a_head_only_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LAST) |=> $stable(r_head))
        else $error("head moved outside the last-car step");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_count))
        else $error("scan index past the car count");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((PTR_W+1)'(ram_waddr) < (PTR_W+1)'(MAX_CARS)))
        else $error("store write outside the ring");

endmodule

`default_nettype wire
